// ===== rtl/kdpc_pkg.sv =====
// Shared constants and types for the key debounce / press classifier.
// No dependencies; used by kdpc_key_unit and the core module under rtl/.
package kdpc_pkg;

    // Block sizing
    localparam int KEY_COUNT   = 7;
    localparam int QUEUE_DEPTH = 16;

    // Fixed field widths of the ports
    localparam int MASK_W     = 7;
    localparam int LEVEL_W    = 7;
    localparam int DROP_W     = 3;
    localparam int EV_KEY_W   = 3;
    localparam int LEVEL_OUT_W = 5;
    localparam int BOUNCE_W   = 10;
    localparam int HOLD_W     = 16;

    // Derived widths
    localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W   = EV_KEY_W + 1;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register indexes
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    // Reset values of the registers
    localparam logic [BOUNCE_W-1:0] DEBOUNCE_RESET   = BOUNCE_W'(5);
    localparam logic [HOLD_W-1:0]   LONG_PRESS_RESET = HOLD_W'(100);

    // Item codes
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Per-key debounce and hold state
    typedef struct packed {
        logic                stable;
        logic                long_done;
        logic                armed;
        logic [BOUNCE_W-1:0] bounce;
        logic [HOLD_W-1:0]   hold;
    } key_state_t;

    // What one key step asks of the sequencer
    typedef struct packed {
        logic push;
        logic is_long;
        logic start;
    } key_event_t;

endpackage

// ===== rtl/kdpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kdpc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/kdpc_key_unit.sv =====
// Shared per-key step: debounce, hold timing and event classification for one key.
// Depends on kdpc_pkg.
module kdpc_key_unit (
    input  kdpc_pkg::key_state_t          cur,
    input  logic                          raw_pressed,
    input  logic [kdpc_pkg::BOUNCE_W-1:0] bounce_limit,
    input  logic [kdpc_pkg::HOLD_W-1:0]   long_press_ticks,
    output kdpc_pkg::key_state_t          nxt,
    output kdpc_pkg::key_event_t          evt
);

    logic [kdpc_pkg::BOUNCE_W-1:0] need;
    logic [kdpc_pkg::BOUNCE_W-1:0] bounce_inc;
    logic                          just_pressed;

    // Zero debounce setting acts as one
    assign need       = (bounce_limit == '0) ? kdpc_pkg::BOUNCE_W'(1) : bounce_limit;
    assign bounce_inc = cur.bounce + kdpc_pkg::BOUNCE_W'(1);

    always_comb
    begin
        nxt          = cur;
        evt          = '0;
        just_pressed = 1'b0;

        // Debounce: flip the stable level after enough differing samples
        if (raw_pressed == cur.stable)
        begin
            nxt.bounce = '0;
        end
        else
        begin
            nxt.bounce = bounce_inc;
            if (bounce_inc >= need)
            begin
                nxt.stable = raw_pressed;
                nxt.bounce = '0;
                if (raw_pressed)
                begin
                    nxt.hold      = '0;
                    nxt.long_done = 1'b0;
                    nxt.armed     = 1'b1;
                    just_pressed  = 1'b1;
                end
            end
        end

        // Hold timing: advance the saturating counter and fire one long event
        if (nxt.stable && !nxt.long_done)
        begin
            if (!just_pressed && (nxt.hold != '1))
            begin
                nxt.hold = nxt.hold + kdpc_pkg::HOLD_W'(1);
            end
            if (nxt.hold >= long_press_ticks)
            begin
                nxt.long_done = 1'b1;
                evt.push      = 1'b1;
                evt.is_long   = 1'b1;
            end
        end

        // Release: short event when armed and no long event fired
        if (!nxt.stable)
        begin
            if (nxt.armed && !nxt.long_done)
            begin
                evt.push    = 1'b1;
                evt.is_long = 1'b0;
            end
            nxt.armed     = 1'b0;
            nxt.long_done = 1'b0;
        end

        evt.start = just_pressed;
    end

endmodule

// ===== rtl/key_debounce_press_classifier_core.sv =====
// Key debounce and short/long press classifier, top level.
// Depends on kdpc_pkg, kdpc_key_unit and kdpc_ram.
//
// A scan word (op=0) walks the keys one per cycle through a single shared key
// unit in S_SCAN, then its result word is loaded from S_DONE and the block
// returns to S_IDLE to take the next word; each key step may push one event
// into the event queue. A pop word (op=1) passes S_POP and, on a non-empty
// queue, S_POP_WAIT for the registered read of the queue RAM before S_DONE.
// The block takes one word at a time; a finished result sits in the output
// register while the next input word is accepted, and a result that cannot be
// loaded because the output register is still full holds off input. On a full
// queue the oldest event is dropped and counted.
// Registers: debounce count at byte address 0, long-press delay at 4.
module key_debounce_press_classifier_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kdpc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [kdpc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [kdpc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [kdpc_pkg::LEVEL_W-1:0]        raw_levels,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [kdpc_pkg::MASK_W-1:0]         pressed_mask,
    output logic [kdpc_pkg::MASK_W-1:0]         press_start_mask,
    output logic [kdpc_pkg::DROP_W-1:0]         dropped_count,
    output logic                                event_valid,
    output logic [kdpc_pkg::EV_KEY_W-1:0]       event_key,
    output logic                                event_long,
    output logic [kdpc_pkg::LEVEL_OUT_W-1:0]    queue_level
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_POP_WAIT,
        S_DONE
    } state_t;

    localparam logic [kdpc_pkg::KEY_IDX_W-1:0] KEY_LAST =
        kdpc_pkg::KEY_IDX_W'(kdpc_pkg::KEY_COUNT - 1);
    localparam logic [kdpc_pkg::PTR_W-1:0] PTR_LAST =
        kdpc_pkg::PTR_W'(kdpc_pkg::QUEUE_DEPTH - 1);
    localparam logic [kdpc_pkg::CNT_W-1:0] CNT_FULL =
        kdpc_pkg::CNT_W'(kdpc_pkg::QUEUE_DEPTH);

    state_t state_reg;

    // Configuration registers
    logic [kdpc_pkg::BOUNCE_W-1:0] debounce_reg;
    logic [kdpc_pkg::HOLD_W-1:0]   long_press_reg;

    // Per-key state
    kdpc_pkg::key_state_t key_reg [kdpc_pkg::KEY_COUNT];

    // Work registers of the current item
    logic                               op_reg;
    logic [kdpc_pkg::LEVEL_W-1:0]       levels_reg;
    logic [kdpc_pkg::KEY_IDX_W-1:0]     key_idx_reg;
    logic [kdpc_pkg::KEY_COUNT-1:0]     start_reg;
    logic [kdpc_pkg::DROP_W-1:0]        dropped_reg;
    logic                               ev_valid_reg;
    logic [kdpc_pkg::EV_KEY_W-1:0]      ev_key_reg;
    logic                               ev_long_reg;

    // Queue pointers
    logic [kdpc_pkg::PTR_W-1:0] head_reg;
    logic [kdpc_pkg::PTR_W-1:0] tail_reg;
    logic [kdpc_pkg::CNT_W-1:0] count_reg;

    // Output register
    logic                               out_valid_reg;
    logic [kdpc_pkg::MASK_W-1:0]        pressed_out_reg;
    logic [kdpc_pkg::MASK_W-1:0]        start_out_reg;
    logic [kdpc_pkg::DROP_W-1:0]        dropped_out_reg;
    logic                               ev_valid_out_reg;
    logic [kdpc_pkg::EV_KEY_W-1:0]      ev_key_out_reg;
    logic                               ev_long_out_reg;
    logic [kdpc_pkg::LEVEL_OUT_W-1:0]   level_out_reg;

    // Key unit hookup
    kdpc_pkg::key_state_t                         unit_nxt;
    kdpc_pkg::key_event_t                         unit_evt;
    logic [kdpc_pkg::LEVEL_W+kdpc_pkg::KEY_COUNT-1:0] levels_ext;
    logic                                         raw_pressed;

    // Stable and start vectors widened to the mask width
    logic [kdpc_pkg::KEY_COUNT-1:0]                   stable_vec;
    logic [kdpc_pkg::MASK_W+kdpc_pkg::KEY_COUNT-1:0]  stable_ext;
    logic [kdpc_pkg::MASK_W+kdpc_pkg::KEY_COUNT-1:0]  start_ext;

    // Queue RAM ports
    logic                              ram_wr_en;
    logic [kdpc_pkg::ENTRY_W-1:0]      ram_wr_data;
    logic                              ram_rd_en;
    logic [kdpc_pkg::ENTRY_W-1:0]      ram_rd_data;

    logic in_fire;
    logic cfg_write;
    logic out_free;
    logic out_load;
    logic queue_full;

    // Keys beyond the input width read level 0, which means pressed
    assign levels_ext  = {{kdpc_pkg::KEY_COUNT{1'b0}}, levels_reg};
    assign raw_pressed = ~levels_ext[key_idx_reg];

    kdpc_key_unit u_key_unit (
        .cur              (key_reg[key_idx_reg]),
        .raw_pressed      (raw_pressed),
        .bounce_limit     (debounce_reg),
        .long_press_ticks (long_press_reg),
        .nxt              (unit_nxt),
        .evt              (unit_evt)
    );

    always_comb
    begin
        for (int i = 0; i < kdpc_pkg::KEY_COUNT; i++)
        begin
            stable_vec[i] = key_reg[i].stable;
        end
    end

    assign stable_ext = {{kdpc_pkg::MASK_W{1'b0}}, stable_vec};
    assign start_ext  = {{kdpc_pkg::MASK_W{1'b0}}, start_reg};

    // Queue RAM: push at tail during a key step, read at head on a pop
    assign queue_full  = (count_reg == CNT_FULL);
    assign ram_wr_en   = (state_reg == S_SCAN) && unit_evt.push;
    assign ram_wr_data = {unit_evt.is_long, kdpc_pkg::EV_KEY_W'(key_idx_reg)};
    assign ram_rd_en   = (state_reg == S_POP) && (count_reg != '0);

    kdpc_ram #(
        .WIDTH (kdpc_pkg::ENTRY_W),
        .DEPTH (kdpc_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    // Handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == S_DONE) && out_free;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register read-back
    always_comb
    begin
        case (paddr[2])
            kdpc_pkg::REG_DEBOUNCE:   prdata = kdpc_pkg::APB_DATA_W'(debounce_reg);
            kdpc_pkg::REG_LONG_PRESS: prdata = kdpc_pkg::APB_DATA_W'(long_press_reg);
            default:                  prdata = '0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= kdpc_pkg::DEBOUNCE_RESET;
            long_press_reg <= kdpc_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                kdpc_pkg::REG_DEBOUNCE:   debounce_reg   <= pwdata[kdpc_pkg::BOUNCE_W-1:0];
                kdpc_pkg::REG_LONG_PRESS: long_press_reg <= pwdata[kdpc_pkg::HOLD_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Sequencer, key state, queue pointers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            for (int i = 0; i < kdpc_pkg::KEY_COUNT; i++)
            begin
                key_reg[i] <= '0;
            end
            op_reg           <= kdpc_pkg::OP_SCAN;
            levels_reg       <= '0;
            key_idx_reg      <= '0;
            start_reg        <= '0;
            dropped_reg      <= '0;
            ev_valid_reg     <= 1'b0;
            ev_key_reg       <= '0;
            ev_long_reg      <= 1'b0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            pressed_out_reg  <= '0;
            start_out_reg    <= '0;
            dropped_out_reg  <= '0;
            ev_valid_out_reg <= 1'b0;
            ev_key_out_reg   <= '0;
            ev_long_out_reg  <= 1'b0;
            level_out_reg    <= '0;
        end
        else
        begin
            // Raise valid on a load, drop it once the word is taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg       <= op;
                        levels_reg   <= raw_levels;
                        key_idx_reg  <= '0;
                        start_reg    <= '0;
                        dropped_reg  <= '0;
                        ev_valid_reg <= 1'b0;
                        ev_key_reg   <= '0;
                        ev_long_reg  <= 1'b0;
                        state_reg    <= (op == kdpc_pkg::OP_POP) ? S_POP : S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    // Advance one key through the shared unit
                    key_reg[key_idx_reg]   <= unit_nxt;
                    start_reg[key_idx_reg] <= unit_evt.start;
                    if (unit_evt.push)
                    begin
                        tail_reg <= (tail_reg == PTR_LAST) ? '0
                                                           : tail_reg + kdpc_pkg::PTR_W'(1);
                        if (queue_full)
                        begin
                            head_reg <= (head_reg == PTR_LAST) ? '0
                                                               : head_reg + kdpc_pkg::PTR_W'(1);
                            if (dropped_reg != '1)
                            begin
                                dropped_reg <= dropped_reg + kdpc_pkg::DROP_W'(1);
                            end
                        end
                        else
                        begin
                            count_reg <= count_reg + kdpc_pkg::CNT_W'(1);
                        end
                    end
                    if (key_idx_reg == KEY_LAST)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        key_idx_reg <= key_idx_reg + kdpc_pkg::KEY_IDX_W'(1);
                    end
                end

                S_POP:
                begin
                    // Read the oldest word and retire it
                    if (count_reg != '0)
                    begin
                        head_reg  <= (head_reg == PTR_LAST) ? '0
                                                            : head_reg + kdpc_pkg::PTR_W'(1);
                        count_reg <= count_reg - kdpc_pkg::CNT_W'(1);
                        state_reg <= S_POP_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_POP_WAIT:
                begin
                    ev_valid_reg <= 1'b1;
                    ev_key_reg   <= ram_rd_data[kdpc_pkg::EV_KEY_W-1:0];
                    ev_long_reg  <= ram_rd_data[kdpc_pkg::EV_KEY_W];
                    state_reg    <= S_DONE;
                end

                S_DONE:
                begin
                    // Hold until the output register is free, then load it
                    if (out_free)
                    begin
                        pressed_out_reg  <= stable_ext[kdpc_pkg::MASK_W-1:0];
                        start_out_reg    <= (op_reg == kdpc_pkg::OP_SCAN)
                                            ? start_ext[kdpc_pkg::MASK_W-1:0] : '0;
                        dropped_out_reg  <= dropped_reg;
                        ev_valid_out_reg <= ev_valid_reg;
                        ev_key_out_reg   <= ev_key_reg;
                        ev_long_out_reg  <= ev_long_reg;
                        level_out_reg    <= kdpc_pkg::LEVEL_OUT_W'(count_reg);
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign pressed_mask     = pressed_out_reg;
    assign press_start_mask = start_out_reg;
    assign dropped_count    = dropped_out_reg;
    assign event_valid      = ev_valid_out_reg;
    assign event_key        = ev_key_out_reg;
    assign event_long       = ev_long_out_reg;
    assign queue_level      = level_out_reg;

endmodule

// ===== tb/kdpc_press_checker.sv =====
// Scoreboard for the key debounce / press classifier: predicts every result word
// from the accepted input words and register writes, and compares in order.
// Depends on kdpc_pkg for widths, register indexes and item codes.
`timescale 1ns / 100ps

module kdpc_press_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kdpc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [kdpc_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic                               pready,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               op,
    input  logic [kdpc_pkg::LEVEL_W-1:0]       raw_levels,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [kdpc_pkg::MASK_W-1:0]        pressed_mask,
    input  logic [kdpc_pkg::MASK_W-1:0]        press_start_mask,
    input  logic [kdpc_pkg::DROP_W-1:0]        dropped_count,
    input  logic                               event_valid,
    input  logic [kdpc_pkg::EV_KEY_W-1:0]      event_key,
    input  logic                               event_long,
    input  logic [kdpc_pkg::LEVEL_OUT_W-1:0]   queue_level,
    output int                                 errors,
    output int                                 pending,
    output int                                 checked,
    output int                                 long_seen,
    output int                                 short_seen,
    output int                                 drops_seen
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [kdpc_pkg::MASK_W-1:0]      pressed;
        logic [kdpc_pkg::MASK_W-1:0]      start;
        logic [kdpc_pkg::DROP_W-1:0]      dropped;
        logic                             ev_valid;
        logic [kdpc_pkg::EV_KEY_W-1:0]    ev_key;
        logic                             ev_long;
        logic [kdpc_pkg::LEVEL_OUT_W-1:0] level;
    } press_result_t;

    // Shadow of the block: registers, per-key debounce state, event queue
    logic [kdpc_pkg::BOUNCE_W-1:0]  debounce_cfg;
    logic [kdpc_pkg::HOLD_W-1:0]    long_cfg;
    logic [kdpc_pkg::KEY_COUNT-1:0] key_down;
    logic [kdpc_pkg::KEY_COUNT-1:0] long_sent;
    logic [kdpc_pkg::KEY_COUNT-1:0] armed;
    logic [kdpc_pkg::BOUNCE_W-1:0]  bounce [kdpc_pkg::KEY_COUNT];
    logic [kdpc_pkg::HOLD_W-1:0]    held [kdpc_pkg::KEY_COUNT];
    logic [kdpc_pkg::ENTRY_W-1:0]   held_events [$];
    press_result_t                  expected_results [$];

    // Append one event, dropping the oldest on a full queue; returns drops
    function automatic int log_event(input int key, input logic is_long);
        int lost;
        lost = 0;
        if (held_events.size() >= kdpc_pkg::QUEUE_DEPTH)
        begin
            void'(held_events.pop_front());
            lost = 1;
        end
        held_events.push_back({is_long, kdpc_pkg::EV_KEY_W'(key)});
        return lost;
    endfunction

    // One scan tick across all keys, in key order
    task automatic predict_scan(input logic [kdpc_pkg::LEVEL_W-1:0] levels,
                                output press_result_t r);
        logic [kdpc_pkg::BOUNCE_W-1:0] need;
        logic                          raw;
        logic                          fresh;
        int                            drops;
        need  = (debounce_cfg == '0) ? kdpc_pkg::BOUNCE_W'(1) : debounce_cfg;
        drops = 0;
        r     = '0;
        for (int k = 0; k < kdpc_pkg::KEY_COUNT; k++)
        begin
            raw   = ~levels[k];
            fresh = 1'b0;
            // debounce: flip only after enough consecutive differing samples
            if (raw == key_down[k])
            begin
                bounce[k] = '0;
            end
            else
            begin
                bounce[k] = bounce[k] + 1'b1;
                if (bounce[k] >= need)
                begin
                    key_down[k] = raw;
                    bounce[k]   = '0;
                    if (raw)
                    begin
                        held[k]      = '0;
                        long_sent[k] = 1'b0;
                        armed[k]     = 1'b1;
                        fresh        = 1'b1;
                        r.start[k]   = 1'b1;
                    end
                end
            end
            // hold timer, saturating, fires the long event once
            if (key_down[k] && !long_sent[k])
            begin
                if (!fresh && held[k] != '1)
                    held[k] = held[k] + 1'b1;
                if (held[k] >= long_cfg)
                begin
                    long_sent[k] = 1'b1;
                    drops += log_event(k, 1'b1);
                end
            end
            // release: short event unless the long one already fired
            if (!key_down[k])
            begin
                if (armed[k] && !long_sent[k])
                    drops += log_event(k, 1'b0);
                armed[k]     = 1'b0;
                long_sent[k] = 1'b0;
            end
        end
        r.dropped = (drops > 7) ? kdpc_pkg::DROP_W'(7) : kdpc_pkg::DROP_W'(drops);
        r.pressed = key_down;
        r.level   = kdpc_pkg::LEVEL_OUT_W'(held_events.size());
    endtask

    task automatic predict_pop(output press_result_t r);
        logic [kdpc_pkg::ENTRY_W-1:0] entry;
        r = '0;
        if (held_events.size() > 0)
        begin
            entry      = held_events.pop_front();
            r.ev_valid = 1'b1;
            r.ev_key   = entry[kdpc_pkg::EV_KEY_W-1:0];
            r.ev_long  = entry[kdpc_pkg::EV_KEY_W];
        end
        r.pressed = key_down;
        r.level   = kdpc_pkg::LEVEL_OUT_W'(held_events.size());
    endtask

    // Watch all three ports; results are checked before new words are predicted
    always @(posedge clk or negedge rst_n)
    begin : watch
        press_result_t want;
        press_result_t got;
        if (!rst_n)
        begin
            debounce_cfg = kdpc_pkg::DEBOUNCE_RESET;
            long_cfg     = kdpc_pkg::LONG_PRESS_RESET;
            key_down     = '0;
            long_sent    = '0;
            armed        = '0;
            for (int k = 0; k < kdpc_pkg::KEY_COUNT; k++)
            begin
                bounce[k] = '0;
                held[k]   = '0;
            end
            held_events.delete();
            expected_results.delete();
            errors     = 0;
            checked    = 0;
            long_seen  = 0;
            short_seen = 0;
            drops_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{pressed: pressed_mask, start: press_start_mask,
                        dropped: dropped_count, ev_valid: event_valid,
                        ev_key: event_key, ev_long: event_long, level: queue_level};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result word with nothing expected: pressed=%h level=%0d",
                                 $realtime, got.pressed, got.level);
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                        begin
                            $display("%0t: result %0d mismatch", $realtime, checked);
                            $display("  want pressed=%h start=%h drop=%0d ev=%b key=%0d long=%b level=%0d",
                                     want.pressed, want.start, want.dropped, want.ev_valid,
                                     want.ev_key, want.ev_long, want.level);
                            $display("  got  pressed=%h start=%h drop=%0d ev=%b key=%0d long=%b level=%0d",
                                     got.pressed, got.start, got.dropped, got.ev_valid,
                                     got.ev_key, got.ev_long, got.level);
                        end
                    end
                    if (want.ev_valid && want.ev_long)
                        long_seen++;
                    else if (want.ev_valid)
                        short_seen++;
                    drops_seen += want.dropped;
                end
            end
            if (in_valid && in_ready)
            begin
                if (op == kdpc_pkg::OP_SCAN)
                    predict_scan(raw_levels, want);
                else
                    predict_pop(want);
                expected_results.push_back(want);
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[kdpc_pkg::APB_ADDR_W-1:2] == kdpc_pkg::REG_DEBOUNCE)
                    debounce_cfg = pwdata[kdpc_pkg::BOUNCE_W-1:0];
                else if (paddr[kdpc_pkg::APB_ADDR_W-1:2] == kdpc_pkg::REG_LONG_PRESS)
                    long_cfg = pwdata[kdpc_pkg::HOLD_W-1:0];
            end
        end
        pending <= expected_results.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the key debounce / press classifier testbench: clock, reset, register
// writes, input words and output back-pressure; verdict from kdpc_press_checker.
// Depends on kdpc_pkg, key_debounce_press_classifier_core and kdpc_press_checker.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 20;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [kdpc_pkg::APB_ADDR_W-1:0]  paddr = '0;
    logic [kdpc_pkg::APB_DATA_W-1:0]  pwdata = '0;
    logic [kdpc_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic                             op = kdpc_pkg::OP_SCAN;
    logic [kdpc_pkg::LEVEL_W-1:0]     raw_levels = '1;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [kdpc_pkg::MASK_W-1:0]      pressed_mask;
    logic [kdpc_pkg::MASK_W-1:0]      press_start_mask;
    logic [kdpc_pkg::DROP_W-1:0]      dropped_count;
    logic                             event_valid;
    logic [kdpc_pkg::EV_KEY_W-1:0]    event_key;
    logic                             event_long;
    logic [kdpc_pkg::LEVEL_OUT_W-1:0] queue_level;

    int errors, pending, checked, long_seen, short_seen, drops_seen;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int holds_asked   = 0;
    int holds_done    = 0;
    int words_sent    = 0;
    int settings_used = 0;
    int cycle_count   = 0;
    logic [kdpc_pkg::LEVEL_W-1:0] pin_plan = '1;

    key_debounce_press_classifier_core dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .raw_levels(raw_levels),
        .out_valid(out_valid), .out_ready(out_ready),
        .pressed_mask(pressed_mask), .press_start_mask(press_start_mask),
        .dropped_count(dropped_count), .event_valid(event_valid),
        .event_key(event_key), .event_long(event_long), .queue_level(queue_level)
    );

    kdpc_press_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .raw_levels(raw_levels),
        .out_valid(out_valid), .out_ready(out_ready),
        .pressed_mask(pressed_mask), .press_start_mask(press_start_mask),
        .dropped_count(dropped_count), .event_valid(event_valid),
        .event_key(event_key), .event_long(event_long), .queue_level(queue_level),
        .errors(errors), .pending(pending), .checked(checked),
        .long_seen(long_seen), .short_seen(short_seen), .drops_seen(drops_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("key_debounce_press_classifier_core test failed");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked for
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                out_ready <= 1'b0;
            end
            else if (holds_done != holds_asked)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                holds_done++;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one word; valid stays up across back-to-back words
    task automatic send_word(input logic word_op,
                             input logic [kdpc_pkg::LEVEL_W-1:0] word_levels);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= word_op;
        raw_levels <= word_levels;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Drop valid and wait for every outstanding result word
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [kdpc_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input int debounce, input int long_press);
        settle();
        write_reg(kdpc_pkg::REG_DEBOUNCE, kdpc_pkg::APB_DATA_W'(debounce));
        write_reg(kdpc_pkg::REG_LONG_PRESS, kdpc_pkg::APB_DATA_W'(long_press));
        settings_used++;
    endtask

    // Mostly plausible key activity: held levels that change now and then,
    // with short glitches, pops mixed in, and some fully random scan words
    task automatic key_activity(input int count, input int toggle_pct, input int pop_pct,
                                input bit hold_off);
        logic [kdpc_pkg::LEVEL_W-1:0] glitch;
        for (int i = 0; i < count; i++)
        begin
            if (hold_off && i == count / 3)
                holds_asked++;
            if ($urandom_range(99) < pop_pct)
            begin
                send_word(kdpc_pkg::OP_POP, kdpc_pkg::LEVEL_W'($urandom_range(0, 127)));
            end
            else if ($urandom_range(99) < 8)
            begin
                send_word(kdpc_pkg::OP_SCAN, kdpc_pkg::LEVEL_W'($urandom_range(0, 127)));
            end
            else
            begin
                glitch = '0;
                for (int k = 0; k < kdpc_pkg::LEVEL_W; k++)
                begin
                    if ($urandom_range(99) < toggle_pct)
                        pin_plan[k] = ~pin_plan[k];
                    if ($urandom_range(99) < 4)
                        glitch[k] = 1'b1;
                end
                send_word(kdpc_pkg::OP_SCAN, pin_plan ^ glitch);
            end
        end
    endtask

    task automatic set_idling(input int sender, input int receiver);
        settle();
        send_idle_pct = sender;
        stall_pct     = receiver;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset timing, pop on empty, full press then full release
        send_word(kdpc_pkg::OP_POP, 7'h00);
        send_word(kdpc_pkg::OP_SCAN, 7'h7F);
        repeat (5) send_word(kdpc_pkg::OP_SCAN, 7'h00);
        repeat (5) send_word(kdpc_pkg::OP_SCAN, 7'h7F);
        send_word(kdpc_pkg::OP_POP, 7'h7F);

        // Directed: zero debounce and zero long delay, overflow the queue
        set_timing(0, 0);
        send_word(kdpc_pkg::OP_SCAN, 7'h00);
        send_word(kdpc_pkg::OP_SCAN, 7'h7F);
        send_word(kdpc_pkg::OP_SCAN, 7'h00);
        send_word(kdpc_pkg::OP_SCAN, 7'h55);

        // Random phases across timings and idling modes
        set_timing(1, 3);
        set_idling(0, 0);
        key_activity(250, 15, 30, 1'b0);

        set_timing(3, 12);
        set_idling(65, 0);
        key_activity(300, 6, 30, 1'b0);

        set_timing(0, 0);
        set_idling(0, 65);
        key_activity(250, 20, 20, 1'b1);

        set_timing(1023, 0);
        set_idling(29, 29);
        key_activity(100, 10, 30, 1'b0);

        set_timing(2, 65535);
        key_activity(300, 10, 35, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            set_timing($urandom_range(0, 4), $urandom_range(0, 25));
            case (p)
                0: set_idling(0, 0);
                1: set_idling(65, 0);
                2: set_idling(0, 65);
                default: set_idling(29, 29);
            endcase
            key_activity(110, 12, 30, 1'b0);
        end

        settle();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Ran %0d words under %0d timing settings, %0d result words checked.",
                 words_sent, settings_used + 1, checked);
        $display("Popped %0d long and %0d short press events; %0d events dropped on overflow.",
                 long_seen, short_seen, drops_seen);
        if (errors == 0 && pending == 0)
            $display("key_debounce_press_classifier_core test passed");
        else
            $display("key_debounce_press_classifier_core test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/kdpc_pkg.sv
rtl/kdpc_ram.sv
rtl/kdpc_key_unit.sv
rtl/key_debounce_press_classifier_core.sv
tb/kdpc_press_checker.sv
tb/tb.sv
